// ----- hdl/kmp_pkg.sv -----
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants for the KMP substring counter
// Sizes of the pattern and failure-link stores, item encoding and
// engine states.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int MAX_PATTERN = 1024;
  // Address width of the pattern store (MAX_PATTERN entries).
  localparam int PAT_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // Width of a length or prefix position, 0..MAX_PATTERN. Also indexes
  // the failure-link store (MAX_PATTERN + 1 entries).
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int SYM_W = 8;
  localparam int CNT_W = 32;

  typedef enum logic [1:0] {
    OP_PAT_NEW,
    OP_PAT_APPEND,
    OP_TEXT_NEW,
    OP_TEXT_CONT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] symbol;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_LINK
  } bk_state_t;

endpackage

// ----- hdl/kmp_front.sv -----
// ----------------------------------------------------------------------------
// kmp_front: input stage
// Registers each input transaction and classifies it into an operation
// code for the engine.
// ----------------------------------------------------------------------------
module kmp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [kmp_pkg::SYM_W-1:0]   symbol,
  input  logic                        first,
  output logic                        push_valid,
  output kmp_pkg::item_t              push_item,
  input  logic                        push_ready
);

  logic           valid;
  logic           valid_next;
  kmp_pkg::item_t item;
  kmp_pkg::item_t item_next;
  logic           accept;

  assign in_stall   = valid && !push_ready;
  assign accept     = in_valid && !in_stall;
  assign push_valid = valid;
  assign push_item  = item;

  always_comb begin
    valid_next       = accept || (valid && !push_ready);
    item_next        = item;
    if (accept) begin
      item_next.symbol = symbol;
      if (command) begin
        item_next.op = first ? kmp_pkg::OP_TEXT_NEW : kmp_pkg::OP_TEXT_CONT;
      end else begin
        item_next.op = first ? kmp_pkg::OP_PAT_NEW : kmp_pkg::OP_PAT_APPEND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

endmodule

// ----- hdl/kmp_queue.sv -----
// ----------------------------------------------------------------------------
// kmp_queue: two-entry queue between front and engine
// Lets the input stage keep taking transactions while the engine walks
// failure links.
// ----------------------------------------------------------------------------
module kmp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  kmp_pkg::item_t push_item,
  output logic           push_ready,
  output logic           pop_valid,
  output kmp_pkg::item_t pop_item,
  input  logic           pop_ready
);

  kmp_pkg::item_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- hdl/kmp_back.sv -----
// ----------------------------------------------------------------------------
// kmp_back: matching engine
// Holds the pattern and failure-link stores, builds links as pattern
// bytes arrive, walks links for text bytes and drives the result register.
// ----------------------------------------------------------------------------
module kmp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pop_valid,
  input  kmp_pkg::item_t              pop_item,
  output logic                        pop_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        match_found,
  output logic [kmp_pkg::CNT_W-1:0]   match_count,
  output logic [kmp_pkg::LEN_W-1:0]   pattern_length,
  output logic                        overflow
);

  localparam int LW = kmp_pkg::LEN_W;
  localparam int AW = kmp_pkg::PAT_AW;
  localparam int SW = kmp_pkg::SYM_W;
  localparam int CW = kmp_pkg::CNT_W;

  // stores
  logic [SW-1:0] pat_mem  [kmp_pkg::MAX_PATTERN];
  logic [LW-1:0] link_mem [kmp_pkg::MAX_PATTERN + 1];
  logic [SW-1:0] pat_rdata;
  logic [LW-1:0] link_rdata;
  logic          pat_we;
  logic [AW-1:0] pat_waddr;
  logic          link_we;
  logic [LW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;

  // engine state
  kmp_pkg::bk_state_t state, state_next;
  logic [LW-1:0] sl, sl_next;
  logic [LW-1:0] bp, bp_next;
  logic [LW-1:0] mp, mp_next;
  logic [CW-1:0] count, count_next;
  logic [LW-1:0] j, j_next;
  logic [SW-1:0] sym, sym_next;
  logic          is_text, is_text_next;

  // result register
  logic          out_valid_next;
  logic          found_next;
  logic [CW-1:0] count_out_next;
  logic [LW-1:0] len_next;
  logic          ovf_next;
  logic          out_free;

  // scratch
  logic          first_b;
  logic [LW-1:0] sl_e;
  logic [LW-1:0] bp_e;
  logic [LW-1:0] mp_e;
  logic [CW-1:0] cnt_e;
  logic [LW-1:0] jj;
  logic          emit;

  assign out_free  = !out_valid || !out_stall;
  assign pop_ready = (state == kmp_pkg::BK_IDLE) && out_free;

  always_comb begin
    state_next     = state;
    sl_next        = sl;
    bp_next        = bp;
    mp_next        = mp;
    count_next     = count;
    j_next         = j;
    sym_next       = sym;
    is_text_next   = is_text;
    pat_we         = 1'b0;
    pat_waddr      = sl[AW-1:0];
    link_we        = 1'b0;
    link_waddr     = sl;
    link_wdata     = j;
    emit           = 1'b0;
    found_next     = 1'b0;
    count_out_next = count;
    len_next       = sl;
    ovf_next       = 1'b0;
    first_b        = (pop_item.op == kmp_pkg::OP_PAT_NEW) ||
                     (pop_item.op == kmp_pkg::OP_TEXT_NEW);
    sl_e           = first_b ? '0 : sl;
    bp_e           = first_b ? '0 : bp;
    mp_e           = first_b ? '0 : mp;
    cnt_e          = first_b ? '0 : count;
    jj             = j;

    case (state)
      kmp_pkg::BK_IDLE: begin
        if (pop_valid && out_free) begin
          sym_next = pop_item.symbol;
          if ((pop_item.op == kmp_pkg::OP_PAT_NEW) ||
              (pop_item.op == kmp_pkg::OP_PAT_APPEND)) begin
            sl_next      = sl_e;
            bp_next      = bp_e;
            mp_next      = '0;
            is_text_next = 1'b0;
            if (sl_e >= LW'(kmp_pkg::MAX_PATTERN)) begin
              // no room: drop the byte
              emit     = 1'b1;
              len_next = sl_e;
              ovf_next = 1'b1;
            end else begin
              pat_we    = 1'b1;
              pat_waddr = sl_e[AW-1:0];
              if (sl_e == '0) begin
                bp_next    = '0;
                sl_next    = LW'(1);
                link_we    = 1'b1;
                link_waddr = LW'(1);
                link_wdata = '0;
                emit       = 1'b1;
                len_next   = LW'(1);
              end else begin
                j_next     = bp_e;
                state_next = kmp_pkg::BK_WALK;
              end
            end
          end else begin
            count_next   = cnt_e;
            mp_next      = mp_e;
            is_text_next = 1'b1;
            if (sl == '0) begin
              emit           = 1'b1;
              count_out_next = cnt_e;
            end else begin
              j_next     = (mp_e >= sl) ? '0 : mp_e;
              state_next = kmp_pkg::BK_WALK;
            end
          end
        end
      end

      kmp_pkg::BK_WALK: begin
        if ((j != '0) && (j < sl) && (pat_rdata != sym)) begin
          j_next = link_rdata;
        end else begin
          jj = ((j < sl) && (pat_rdata == sym)) ? (j + LW'(1)) : j;
          if (!is_text) begin
            bp_next    = jj;
            sl_next    = sl + LW'(1);
            link_we    = 1'b1;
            link_waddr = sl + LW'(1);
            link_wdata = jj;
            emit       = 1'b1;
            len_next   = sl + LW'(1);
            state_next = kmp_pkg::BK_IDLE;
          end else if (jj == sl) begin
            // full match: count it, then fall back through link of whole pattern
            count_next = (count == {CW{1'b1}}) ? count : (count + CW'(1));
            j_next     = sl;
            state_next = kmp_pkg::BK_LINK;
          end else begin
            mp_next    = jj;
            emit       = 1'b1;
            state_next = kmp_pkg::BK_IDLE;
          end
        end
      end

      kmp_pkg::BK_LINK: begin
        mp_next    = link_rdata;
        emit       = 1'b1;
        found_next = 1'b1;
        state_next = kmp_pkg::BK_IDLE;
      end

      default: begin
        state_next = kmp_pkg::BK_IDLE;
      end
    endcase

    out_valid_next = emit || (out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kmp_pkg::BK_IDLE;
      sl        <= '0;
      bp        <= '0;
      mp        <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sl        <= sl_next;
      bp        <= bp_next;
      mp        <= mp_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    j       <= j_next;
    sym     <= sym_next;
    is_text <= is_text_next;
    if (emit) begin
      match_found    <= found_next;
      match_count    <= count_out_next;
      pattern_length <= len_next;
      overflow       <= ovf_next;
    end
  end

  // stores: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pop_item.symbol;
    end
    pat_rdata <= pat_mem[j_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata <= link_mem[j_next];
  end

endmodule

// ----- hdl/kmp_substring_counter_top.sv -----
// ----------------------------------------------------------------------------
// kmp_substring_counter_top: KMP occurrence counter
// Loads a pattern byte by byte, then counts overlapping occurrences of it
// in a streamed text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): command 0 appends a pattern byte,
//   command 1 matches a text byte; first starts a new pattern or a new text
//   with the count cleared. Each input transaction gives exactly one output
//   transaction (out_valid / out_stall) with match_found, match_count,
//   pattern_length and overflow.
//   Flow: an input transaction is registered, queued (two entries) and
//   then run by the engine. A dropped pattern byte, the first byte of a
//   pattern and a text byte against an empty pattern are finished in the
//   engine's idle state. Other bytes go on to the walk state, which follows
//   failure links one at a time, and a full match adds the link state to
//   read the link of the whole pattern. The engine takes no new byte until
//   it is back in idle; each store has a single read port.
//   Reset clears lengths, positions and the count; the pattern and link
//   stores are not cleared and need no clearing pass. A stalled result
//   holds in the output register; the engine then stops taking queued work,
//   and in_stall rises once the queue and input register are full.
// ----------------------------------------------------------------------------
module kmp_substring_counter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [kmp_pkg::SYM_W-1:0]   symbol,
  input  logic                        first,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        match_found,
  output logic [kmp_pkg::CNT_W-1:0]   match_count,
  output logic [kmp_pkg::LEN_W-1:0]   pattern_length,
  output logic                        overflow
);

  // front -> queue
  logic           push_valid;
  kmp_pkg::item_t push_item;
  logic           push_ready;

  // queue -> engine
  logic           pop_valid;
  kmp_pkg::item_t pop_item;
  logic           pop_ready;

  kmp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .symbol     (symbol),
    .first      (first),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  kmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // engine owns the stores and the result register
  kmp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_item       (pop_item),
    .pop_ready      (pop_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .match_found    (match_found),
    .match_count    (match_count),
    .pattern_length (pattern_length),
    .overflow       (overflow)
  );

endmodule

// ----- tb/kmp_result_checker.sv -----
// ----------------------------------------------------------------------------
// kmp_result_checker: scoreboard for the KMP substring counter
// Watches both channels, keeps its own pattern, link table and match state,
// predicts one result per input transaction and compares in order.
// ----------------------------------------------------------------------------
package kmp_tb_pkg;

  // Values of the command field
  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_TEXT    = 1'b1;

endpackage

module kmp_result_checker
  import kmp_pkg::*;
  import kmp_tb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             command,
  input  logic [SYM_W-1:0] symbol,
  input  logic             first,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             match_found,
  input  logic [CNT_W-1:0] match_count,
  input  logic [LEN_W-1:0] pattern_length,
  input  logic             overflow,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output int               flagged,
  output int               dropped
);

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] count;
    logic [LEN_W-1:0] len;
    logic             drop;
  } outcome_t;

  outcome_t expected_q[$];

  logic [SYM_W-1:0] pat_mem  [MAX_PATTERN];
  logic [LEN_W-1:0] link_mem [MAX_PATTERN+1];
  logic [LEN_W-1:0] pat_len;   // bytes stored
  logic [LEN_W-1:0] border;    // border length of the stored pattern
  logic [LEN_W-1:0] prefix;    // prefix matched so far in the text
  logic [CNT_W-1:0] hits;

  // Walk failure links until sym extends the prefix or it drops to zero.
  function automatic logic [LEN_W-1:0] grow_prefix(input logic [LEN_W-1:0] j,
                                                   input logic [SYM_W-1:0] sym,
                                                   input logic [LEN_W-1:0] limit);
    while (j != 0 && j < limit && pat_mem[j[PAT_AW-1:0]] != sym)
      j = link_mem[j];
    if (j < limit && pat_mem[j[PAT_AW-1:0]] == sym)
      j = j + LEN_W'(1);
    return j;
  endfunction

  task automatic report_error(input string msg);
    if (fail_count < 50)
      $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    outcome_t         want;
    logic [LEN_W-1:0] j;
    if (rst) begin
      pat_len    = '0;
      border     = '0;
      prefix     = '0;
      hits       = '0;
      fail_count = 0;
      checked    = 0;
      flagged    = 0;
      dropped    = 0;
      expected_q.delete();
    end else begin
      // Output side first: a result leaving now never belongs to an input
      // taken at the same edge.
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_error($sformatf("result with nothing pending (count %0d)", match_count));
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (match_found !== want.found)
            report_error($sformatf("match_found %b, want %b", match_found, want.found));
          if (match_count !== want.count)
            report_error($sformatf("match_count %0d, want %0d", match_count, want.count));
          if (pattern_length !== want.len)
            report_error($sformatf("pattern_length %0d, want %0d", pattern_length, want.len));
          if (overflow !== want.drop)
            report_error($sformatf("overflow %b, want %b", overflow, want.drop));
        end
      end

      if (in_valid && !in_stall) begin
        want = '0;
        if (command == CMD_PATTERN) begin
          if (first) begin
            pat_len = '0;
            border  = '0;
          end
          prefix = '0;
          if (pat_len >= LEN_W'(MAX_PATTERN)) begin
            want.drop = 1'b1;
            dropped++;
          end else begin
            pat_mem[pat_len[PAT_AW-1:0]] = symbol;
            border = (pat_len == 0) ? '0 : grow_prefix(border, symbol, pat_len);
            pat_len = pat_len + LEN_W'(1);
            link_mem[pat_len] = border;
          end
        end else begin
          if (first) begin
            hits   = '0;
            prefix = '0;
          end
          if (pat_len != 0) begin
            j = (prefix >= pat_len) ? '0 : prefix;
            j = grow_prefix(j, symbol, pat_len);
            if (j == pat_len) begin
              want.found = 1'b1;
              flagged++;
              if (hits != '1)
                hits = hits + CNT_W'(1);
              j = link_mem[j];
            end
            prefix = j;
          end
        end
        want.count = hits;
        want.len   = pat_len;
        expected_q.push_back(want);
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/tb_kmp_substring_counter_top.sv -----
// ----------------------------------------------------------------------------
// tb_kmp_substring_counter_top: testbench for the KMP substring counter
// Drives pattern and text transactions with random gaps and output stalls,
// including one long output hold-off; a separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_kmp_substring_counter_top;
  import kmp_pkg::*;
  import kmp_tb_pkg::*;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             command   = CMD_PATTERN;
  logic [SYM_W-1:0] symbol    = '0;
  logic             first     = 1'b0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             match_found;
  logic [CNT_W-1:0] match_count;
  logic [LEN_W-1:0] pattern_length;
  logic             overflow;

  int fail_count, pending, checked, flagged, dropped;

  // calm: neither side idles while set. squeeze_go: asks the receiver for
  // its one long hold-off.
  bit calm       = 1'b0;
  bit squeeze_go = 1'b0;
  int sent       = 0;

  // Symbol alphabet of the current random sequence
  logic [SYM_W-1:0] alpha [3];
  int               alpha_n = 2;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  kmp_substring_counter_top dut (.*);

  kmp_result_checker u_checker (.*);

  // Offer one transaction: random gaps first, then hold until taken.
  // Every change happens at a falling edge, all fields of a transaction at the same edge.
  task automatic offer_byte(input logic cmd, input logic [SYM_W-1:0] sym,
                            input logic fst);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    symbol   <= sym;
    first    <= fst;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sent++;
  endtask

  // Mostly alphabet symbols so matches happen; now and then any byte.
  function automatic logic [SYM_W-1:0] draw_symbol();
    if ($urandom_range(99) < 8)
      return SYM_W'($urandom_range(255));
    return alpha[$urandom_range(alpha_n - 1)];
  endfunction

  // Receiver: random stalls, plus one long hold-off so the block backs up
  // and raises in_stall while the sender keeps offering.
  initial begin : receiver
    int hold_left;
    bit squeezed;
    hold_left = 0;
    squeezed  = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_go && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 13);
      end
    end
  end

  initial begin : stimulus
    int               k, r, seq_len, base;
    logic [SYM_W-1:0] sa, sb;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Text against an empty pattern: nothing can match
    offer_byte(CMD_TEXT, 8'h00, 1'b1);
    offer_byte(CMD_TEXT, 8'hFF, 1'b0);
    // Append with nothing stored, then restart the pattern
    offer_byte(CMD_PATTERN, 8'hFF, 1'b0);
    offer_byte(CMD_PATTERN, 8'h00, 1'b1);
    offer_byte(CMD_PATTERN, 8'h00, 1'b0);
    // Overlapping hits of "00 00", a mismatch that walks a link, a re-match
    offer_byte(CMD_TEXT, 8'h00, 1'b1);
    offer_byte(CMD_TEXT, 8'h00, 1'b0);
    offer_byte(CMD_TEXT, 8'h00, 1'b0);
    offer_byte(CMD_TEXT, 8'hFF, 1'b0);
    offer_byte(CMD_TEXT, 8'h00, 1'b0);
    offer_byte(CMD_TEXT, 8'h00, 1'b0);
    // Pattern grows mid-text: position restarts, count is kept
    offer_byte(CMD_PATTERN, 8'hFF, 1'b0);
    offer_byte(CMD_TEXT, 8'h00, 1'b0);
    offer_byte(CMD_TEXT, 8'h00, 1'b0);
    offer_byte(CMD_TEXT, 8'hFF, 1'b0);
    // New text clears the count
    offer_byte(CMD_TEXT, 8'h5A, 1'b1);
    // Single-byte pattern: every equal text byte is a hit
    offer_byte(CMD_PATTERN, 8'hA5, 1'b1);
    offer_byte(CMD_TEXT, 8'hA5, 1'b1);
    offer_byte(CMD_TEXT, 8'hA5, 1'b0);
    offer_byte(CMD_TEXT, 8'h5A, 1'b0);

    // ---- full pattern store ----
    // Periodic pattern of the maximum length gives long link chains; the
    // bytes past capacity must be dropped and flagged.
    sa = SYM_W'($urandom_range(255));
    sb = ~sa;
    for (k = 0; k < MAX_PATTERN; k++)
      offer_byte(CMD_PATTERN, (k % 7 == 6) ? sb : sa, k == 0);
    offer_byte(CMD_PATTERN, 8'h00, 1'b0);
    offer_byte(CMD_PATTERN, 8'hFF, 1'b0);
    offer_byte(CMD_PATTERN, SYM_W'($urandom_range(255)), 1'b0);
    for (k = 0; k < 40; k++)
      offer_byte(CMD_TEXT, (k % 7 == 6 || k == 20) ? sb : sa, k == 0);
    // A new pattern is still accepted once the store was full
    offer_byte(CMD_PATTERN, sa, 1'b1);
    offer_byte(CMD_TEXT, sa, 1'b1);

    // ---- random part ----
    base       = sent;
    squeeze_go = 1'b1;
    while (sent - base < 100) begin
      // one stretch with no idling on either side
      calm = (sent - base >= 30) && (sent - base < 80);
      r = $urandom_range(99);
      if (r < 65) begin
        // well-formed: fresh short pattern over a small alphabet, then text
        alpha_n = $urandom_range(2, 3);
        for (k = 0; k < alpha_n; k++)
          alpha[k] = SYM_W'($urandom_range(255));
        seq_len = $urandom_range(1, 8);
        for (k = 0; k < seq_len; k++)
          offer_byte(CMD_PATTERN, draw_symbol(), k == 0);
        seq_len = $urandom_range(8, 40);
        for (k = 0; k < seq_len; k++)
          offer_byte(CMD_TEXT, draw_symbol(), k == 0);
      end else if (r < 82) begin
        // text carries on, count accumulating
        seq_len = $urandom_range(4, 20);
        for (k = 0; k < seq_len; k++)
          offer_byte(CMD_TEXT, draw_symbol(), 1'b0);
      end else if (r < 92) begin
        // pattern grows in the middle of a text
        seq_len = $urandom_range(1, 3);
        for (k = 0; k < seq_len; k++)
          offer_byte(CMD_PATTERN, draw_symbol(), 1'b0);
      end else begin
        // noise: any command, any byte, any first flag
        seq_len = $urandom_range(1, 6);
        for (k = 0; k < seq_len; k++)
          offer_byte(1'($urandom_range(1)), SYM_W'($urandom_range(255)),
                     $urandom_range(99) < 30);
      end
    end
    calm = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then keep watching so a
    // stray extra result would still be caught.
    while (pending != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Checked %0d transactions: %0d occurrences flagged, %0d pattern bytes dropped,",
             checked, flagged, dropped);
    $display("including a full 1024-byte pattern and one long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
